@@ sv/wifi_station_mac_learner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the station MAC learner
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WIFI_STATION_MAC_LEARNER_MACROS_SVH
`define WIFI_STATION_MAC_LEARNER_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset
`define WSML_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("wsml check failed: condition");

// Antecedent implies consequent in the same cycle
`define WSML_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsml check failed: implication");

// Antecedent implies consequent in the next cycle
`define WSML_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsml check failed: next cycle");

`else

`define WSML_ASSERT_ALWAYS(label, clk, rst, cond)
`define WSML_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WSML_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/wsml_pkg.sv @@
// ----------------------------------------------------------------------------
// wsml_pkg
// Types, codes and constants shared by the station MAC learner modules.
// ----------------------------------------------------------------------------
package wsml_pkg;

   // Table size default
   localparam int MAX_STATIONS_DEF = 64;

   // Field widths
   localparam int MAC_W     = 48;
   localparam int FC_W      = 16;
   localparam int KIND_W    = 2;
   localparam int OUTCOME_W = 3;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 7;
   localparam int CHAN_W    = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BSSID   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_CHANNEL = 2'd1;
   localparam logic [MAC_W-1:0]     BSSID_RESET        = '0;
   localparam logic [CHAN_W-1:0]    CHANNEL_RESET      = 4'd1;

   // Frame header decode
   localparam logic [KIND_W-1:0] KIND_MGMT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
   localparam int                TO_DS_BIT   = 8;
   localparam int                FROM_DS_BIT = 9;
   localparam int                GROUP_BIT   = 0;

   // Classification queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_WRONG_KIND  = 3'd0,
      OUT_BAD_DS      = 3'd1,
      OUT_OTHER_BSSID = 3'd2,
      OUT_GROUP       = 3'd3,
      OUT_KNOWN       = 3'd4,
      OUT_ADDED       = 3'd5,
      OUT_FULL        = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] frame_kind;
      logic [FC_W-1:0]   fc_word;
      logic [MAC_W-1:0]  address_one;
      logic [MAC_W-1:0]  address_two;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [MAC_W-1:0]     station_mac;
      logic [SLOT_W-1:0]    station_slot;
      logic [COUNT_W-1:0]   station_count;
      logic [CHAN_W-1:0]    station_channel;
   } rsp_type;

   // Classified frame passed from front to back
   typedef struct packed {
      outcome_type      outcome;
      logic             lookup;
      logic [MAC_W-1:0] mac;
   } work_type;

endpackage

@@ sv/wsml_front.sv @@
// ----------------------------------------------------------------------------
// wsml_front
// Accepts frame headers, checks kind and DS bits, picks BSSID and client,
// and decides whether the client needs a table lookup.
// ----------------------------------------------------------------------------
module wsml_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  wsml_pkg::req_type            req_data,
   input  logic [wsml_pkg::MAC_W-1:0]   target_bssid,
   output logic                         push_valid,
   input  logic                         push_ready,
   output wsml_pkg::work_type           push_data
);

   logic                       to_ds;
   logic                       from_ds;
   logic [wsml_pkg::MAC_W-1:0] bssid;
   logic [wsml_pkg::MAC_W-1:0] client;

   // Handshake passes straight to the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign to_ds   = req_data.fc_word[wsml_pkg::TO_DS_BIT];
   assign from_ds = req_data.fc_word[wsml_pkg::FROM_DS_BIT];

   // BSSID / client selection by DS direction
   always_comb begin
      if (from_ds) begin
         bssid  = req_data.address_two;
         client = req_data.address_one;
      end else begin
         bssid  = req_data.address_one;
         client = req_data.address_two;
      end
   end

   // Classification
   always_comb begin
      push_data.outcome = wsml_pkg::OUT_WRONG_KIND;
      push_data.lookup  = 1'b0;
      push_data.mac     = '0;
      if (!(req_data.frame_kind inside {wsml_pkg::KIND_MGMT, wsml_pkg::KIND_DATA})) begin
         push_data.outcome = wsml_pkg::OUT_WRONG_KIND;
      end else if (to_ds == from_ds) begin
         push_data.outcome = wsml_pkg::OUT_BAD_DS;
      end else if (bssid != target_bssid) begin
         push_data.outcome = wsml_pkg::OUT_OTHER_BSSID;
         push_data.mac     = client;
      end else if (client[wsml_pkg::GROUP_BIT]) begin
         push_data.outcome = wsml_pkg::OUT_GROUP;
         push_data.mac     = client;
      end else begin
         // outcome is settled by the table engine
         push_data.outcome = wsml_pkg::OUT_KNOWN;
         push_data.lookup  = 1'b1;
         push_data.mac     = client;
      end
   end

endmodule

@@ sv/wsml_queue.sv @@
// ----------------------------------------------------------------------------
// wsml_queue
// Short FIFO of classified frames between the front and the table engine.
// ----------------------------------------------------------------------------
module wsml_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  wsml_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output wsml_pkg::work_type pop_data
);

   wsml_pkg::work_type               entries_ff [wsml_pkg::QUEUE_DEPTH];
   logic [wsml_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [wsml_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [wsml_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [wsml_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [wsml_pkg::QCNT_W-1:0]      cnt_ff;
   logic [wsml_pkg::QCNT_W-1:0]      cnt_in;
   logic                             push;
   logic                             pop;

   assign push_ready = (cnt_ff != wsml_pkg::QCNT_W'(wsml_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/wsml_back.sv @@
// ----------------------------------------------------------------------------
// wsml_back
// Table engine: scans learned MACs one entry per cycle, appends new
// stations and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
`include "wifi_station_mac_learner_macros.svh"

module wsml_back #(
   parameter int MAX_STATIONS = wsml_pkg::MAX_STATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  wsml_pkg::work_type            pop_data,
   input  logic [wsml_pkg::CHAN_W-1:0]   target_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wsml_pkg::rsp_type             rsp_data
);

   localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CNT_W = $clog2(MAX_STATIONS + 1);

   wsml_pkg::back_state_type     state_ff;
   wsml_pkg::back_state_type     state_in;

   logic [wsml_pkg::MAC_W-1:0]   table_mem [MAX_STATIONS];
   logic [wsml_pkg::MAC_W-1:0]   rdata_ff;
   logic [wsml_pkg::MAC_W-1:0]   mac_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             idx_ff;
   logic                         pend_ff;
   logic [IDX_W-1:0]             pend_idx_ff;
   wsml_pkg::outcome_type        res_outcome_ff;
   logic [IDX_W-1:0]             res_slot_ff;
   logic                         rsp_valid_ff;
   wsml_pkg::rsp_type            rsp_data_ff;

   logic                         out_free;
   logic                         start_scan;
   logic                         load_direct;
   logic                         load_res;
   logic                         issue;
   logic                         hit;
   logic                         found;
   logic                         miss_done;
   logic                         append;
   logic                         in_scan;
   logic                         in_done;
   logic                         done_wait;
   logic [IDX_W-1:0]             load_slot;
   logic [IDX_W+wsml_pkg::SLOT_W-1:0]   slot_ext;
   logic [CNT_W+wsml_pkg::COUNT_W-1:0]  count_ext;

   // Control decode
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign issue       = (state_ff == wsml_pkg::BK_SCAN) && (idx_ff < count_ff);
   assign hit         = pend_ff && (rdata_ff == mac_ff);
   assign found       = (state_ff == wsml_pkg::BK_SCAN) && hit;
   assign miss_done   = (state_ff == wsml_pkg::BK_SCAN) && !hit && !issue;
   assign append      = miss_done && (count_ff < CNT_W'(MAX_STATIONS));
   assign in_scan     = (state_ff == wsml_pkg::BK_SCAN);
   assign in_done     = (state_ff == wsml_pkg::BK_DONE);
   assign done_wait   = in_done && !out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wsml_pkg::BK_IDLE: begin
            if (start_scan) begin
               state_in = wsml_pkg::BK_SCAN;
            end
         end
         wsml_pkg::BK_SCAN: begin
            if (found || miss_done) begin
               state_in = wsml_pkg::BK_DONE;
            end
         end
         wsml_pkg::BK_DONE: begin
            if (out_free) begin
               state_in = wsml_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = wsml_pkg::BK_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready   = 1'b0;
      start_scan  = 1'b0;
      load_direct = 1'b0;
      load_res    = 1'b0;
      case (state_ff)
         wsml_pkg::BK_IDLE: begin
            pop_ready   = pop_data.lookup || out_free;
            start_scan  = pop_valid && pop_data.lookup;
            load_direct = pop_valid && !pop_data.lookup && out_free;
         end
         wsml_pkg::BK_DONE: begin
            load_res = out_free;
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsml_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan control and learned count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (state_ff == wsml_pkg::BK_IDLE) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (append) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Scan payload and settled result
   always_ff @(posedge clock) begin
      if (start_scan) begin
         mac_ff <= pop_data.mac;
      end
      if (issue) begin
         pend_idx_ff <= idx_ff[IDX_W-1:0];
      end
      if (found) begin
         res_outcome_ff <= wsml_pkg::OUT_KNOWN;
         res_slot_ff    <= pend_idx_ff;
      end else if (append) begin
         res_outcome_ff <= wsml_pkg::OUT_ADDED;
         res_slot_ff    <= count_ff[IDX_W-1:0];
      end else if (miss_done) begin
         res_outcome_ff <= wsml_pkg::OUT_FULL;
         res_slot_ff    <= '0;
      end
   end

   // Station table: one write and one registered read port
   always_ff @(posedge clock) begin
      if (append) begin
         table_mem[count_ff[IDX_W-1:0]] <= mac_ff;
      end
      if (issue) begin
         rdata_ff <= table_mem[idx_ff[IDX_W-1:0]];
      end
   end

   // Fit slot and count to the result field widths
   assign load_slot = load_res ? res_slot_ff : '0;
   assign slot_ext  = {{wsml_pkg::SLOT_W{1'b0}}, load_slot};
   assign count_ext = {{wsml_pkg::COUNT_W{1'b0}}, count_ff};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_direct || load_res) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct || load_res) begin
         rsp_data_ff.outcome         <= load_res ? res_outcome_ff : pop_data.outcome;
         rsp_data_ff.station_mac     <= load_res ? mac_ff : pop_data.mac;
         rsp_data_ff.station_slot    <= slot_ext[wsml_pkg::SLOT_W-1:0];
         rsp_data_ff.station_count   <= count_ext[wsml_pkg::COUNT_W-1:0];
         rsp_data_ff.station_channel <= target_channel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `WSML_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_STATIONS))
   `WSML_ASSERT_IMPLIES(a_scan_idx, clock, reset, in_scan, idx_ff <= count_ff)
   `WSML_ASSERT_NEXT(a_append_grows, clock, reset, append, count_ff == $past(count_ff) + 1'b1)
   `WSML_ASSERT_NEXT(a_done_holds, clock, reset, done_wait, in_done && $stable(res_outcome_ff))

endmodule

@@ sv/wifi_station_mac_learner.sv @@
// Frames that need no lookup pass through the queue to the result register;
//   a lookup first scans the learned stations in the table engine.
// Throughput: one non-lookup frame per cycle while results are taken; a lookup
//   holds the table engine for its whole scan of the one-entry-per-cycle read port.
// Reset: clears the learned count and queue, sets BSSID 0 and channel 1;
//   table contents are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
// wifi_station_mac_learner
// Learns client MACs of one access point from 802.11 header transactions.
// ----------------------------------------------------------------------------
module wifi_station_mac_learner #(
   parameter int MAX_STATIONS = wsml_pkg::MAX_STATIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  wsml_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wsml_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [wsml_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wsml_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [wsml_pkg::MAC_W-1:0]  target_bssid_ff;
   logic [wsml_pkg::CHAN_W-1:0] target_channel_ff;

   logic                        push_valid;
   logic                        push_ready;
   wsml_pkg::work_type          push_data;
   logic                        pop_valid;
   logic                        pop_ready;
   wsml_pkg::work_type          pop_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_bssid_ff   <= wsml_pkg::BSSID_RESET;
         target_channel_ff <= wsml_pkg::CHANNEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            wsml_pkg::CSR_TARGET_BSSID: begin
               target_bssid_ff <= csr_wdata[wsml_pkg::MAC_W-1:0];
            end
            wsml_pkg::CSR_TARGET_CHANNEL: begin
               target_channel_ff <= csr_wdata[wsml_pkg::CHAN_W-1:0];
            end
            default: begin
               target_bssid_ff <= target_bssid_ff;
            end
         endcase
      end
   end

   wsml_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .target_bssid (target_bssid_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   wsml_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wsml_back #(
      .MAX_STATIONS (MAX_STATIONS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .target_channel (target_channel_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
